FILE: sv/bfie_pkg.sv
// ----------------------------------------------------------------------------
// bfie_pkg: shared types and constants
// Entry and result layouts, register indexes and operation codes for the
// bounded fifo with idle expiry.
// ----------------------------------------------------------------------------
package bfie_pkg;

	localparam int unsigned DEPTH_DEF = 16;

	localparam int unsigned DATA_W    = 32;
	localparam int unsigned CB_W      = 8;
	localparam int unsigned DELTA_W   = 15;
	localparam int unsigned TIMER_W   = 16;
	localparam int unsigned MAXC_W    = 5;
	localparam int unsigned CFG_W     = 16;
	localparam int unsigned CFG_ADDR_W = 2;

	// input tdata: push_data, push_callback, frame_delta, padded to bytes
	localparam int unsigned IN_BITS = DATA_W + CB_W + DELTA_W;
	localparam int unsigned IN_W    = ((IN_BITS + 7) / 8) * 8;

	// result bits ahead of the occupancy count
	localparam int unsigned RES_BITS = 2 + CB_W + DATA_W;

	localparam logic [MAXC_W-1:0]  MAXC_RESET = 5'd16;

	localparam logic [CFG_ADDR_W-1:0] CFG_MAX_COUNT    = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_TIMER_RELOAD = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_TIMER_ENABLE = 2'd2;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef struct packed {
		logic signed [DATA_W-1:0] data;
		logic [CB_W-1:0]          cb;
	} entry_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] released_data;
		logic [CB_W-1:0]          released_callback;
		logic                     callback_fire;
		logic                     released;
	} result_t;

endpackage

FILE: sv/bfie_store.sv
// ----------------------------------------------------------------------------
// bfie_store: entry storage
// One write port at the tail, one registered read port for the head entry,
// with a write-first bypass when both hit the same slot.
// ----------------------------------------------------------------------------
module bfie_store #(
	parameter int unsigned DEPTH = bfie_pkg::DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  bfie_pkg::entry_t         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output bfie_pkg::entry_t         rdata
);

	bfie_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (we && (waddr == raddr)) begin
			rdata <= wdata;
		end else begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: sv/bfie_ctrl.sv
// ----------------------------------------------------------------------------
// bfie_ctrl: queue pointers, count and idle timer
// Works out one push or tick per step and keeps head, tail, occupancy and
// the idle timer.
// ----------------------------------------------------------------------------
module bfie_ctrl #(
	parameter int unsigned DEPTH = bfie_pkg::DEPTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   step,
	input  logic                                   op,
	input  bfie_pkg::entry_t                       item,
	input  logic [bfie_pkg::DELTA_W-1:0]           delta,
	input  logic [bfie_pkg::MAXC_W-1:0]            max_count,
	input  logic signed [bfie_pkg::TIMER_W-1:0]    timer_reload,
	input  logic                                   timer_enable,
	input  bfie_pkg::entry_t                       head_entry,
	output logic                                   wr_en,
	output logic [$clog2(DEPTH)-1:0]               wr_addr,
	output logic [$clog2(DEPTH)-1:0]               rd_addr,
	output bfie_pkg::result_t                      res,
	output logic [$clog2(DEPTH+1)-1:0]             occ
);

	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned CMP_W = (CNT_W > bfie_pkg::MAXC_W) ? CNT_W : bfie_pkg::MAXC_W;
	localparam logic [IDX_W-1:0] LastIdx = IDX_W'(DEPTH - 1);
	localparam logic [CMP_W-1:0] DepthCmp = CMP_W'(DEPTH);
	localparam logic signed [bfie_pkg::TIMER_W:0] TimerMin = -17'sd32768;

	logic [IDX_W-1:0] head_q, tail_q, head_d, tail_d, head_inc, tail_inc;
	logic [CNT_W-1:0] occ_q, occ_d;
	logic signed [bfie_pkg::TIMER_W-1:0] timer_q, timer_d;

	logic [CMP_W-1:0] max_ext, limit;
	logic             evict;
	logic signed [bfie_pkg::TIMER_W:0] timer_dec;
	bfie_pkg::entry_t rel_entry;
	logic             rel;

	assign head_inc = (head_q == LastIdx) ? '0 : head_q + 1'b1;
	assign tail_inc = (tail_q == LastIdx) ? '0 : tail_q + 1'b1;

	// a limit above the storage acts as the storage size
	assign max_ext = CMP_W'(max_count);
	assign limit   = (max_ext > DepthCmp) ? DepthCmp : max_ext;
	// occupancy + 1 > limit; always true on full storage
	assign evict   = (CMP_W'(occ_q) >= limit);

	assign timer_dec = {timer_q[bfie_pkg::TIMER_W-1], timer_q}
		- $signed({2'b00, delta});

	always_comb begin
		head_d    = head_q;
		tail_d    = tail_q;
		occ_d     = occ_q;
		timer_d   = timer_q;
		rel       = 1'b0;
		rel_entry = head_entry;
		wr_en     = 1'b0;
		case (op)
			bfie_pkg::OP_PUSH: begin
				wr_en   = step;
				tail_d  = tail_inc;
				timer_d = timer_reload;
				if (evict) begin
					rel    = 1'b1;
					head_d = head_inc;
					// empty queue with a zero limit: the new entry goes straight out
					if (occ_q == '0) begin
						rel_entry = item;
					end
				end else begin
					occ_d = occ_q + 1'b1;
				end
			end
			bfie_pkg::OP_TICK: begin
				if (occ_q != '0) begin
					if (timer_q < 0) begin
						rel    = 1'b1;
						head_d = head_inc;
						occ_d  = occ_q - 1'b1;
					end else if (timer_enable) begin
						timer_d = (timer_dec < TimerMin) ? TimerMin[bfie_pkg::TIMER_W-1:0]
							: timer_dec[bfie_pkg::TIMER_W-1:0];
					end
				end
			end
			default: begin
				rel = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			occ_q   <= '0;
			timer_q <= '0;
		end else if (step) begin
			head_q  <= head_d;
			tail_q  <= tail_d;
			occ_q   <= occ_d;
			timer_q <= timer_d;
		end
	end

	assign wr_addr = tail_q;
	// prefetch the head that the next step will see
	assign rd_addr = step ? head_d : head_q;

	assign res.released          = rel;
	assign res.callback_fire     = rel && (rel_entry.cb != '0);
	assign res.released_callback = rel ? rel_entry.cb : '0;
	assign res.released_data     = rel ? rel_entry.data : '0;
	assign occ = step ? occ_d : occ_q;

endmodule

FILE: sv/bounded_fifo_idle_expiry.sv
// ----------------------------------------------------------------------------
// bounded_fifo_idle_expiry: bounded fifo with eviction and idle expiry
// Pushes append entries and reload the idle timer; ticks count the timer
// down while it is enabled and release the head once it has gone negative.
// ----------------------------------------------------------------------------
// path: an accepted transaction is held in the input stage register, then
//   in the result register, which drives m_tvalid
// throughput: one transaction per cycle while m_tready does not stall the output; the pointer
//   and timer update is a single pass through bfie_ctrl, head entry prefetched by bfie_store
// reset: queue empty, timer zero, max_count 16, timer_reload 0,
//   timer_enable 0; entry storage holds whatever it held
module bounded_fifo_idle_expiry #(
	parameter int unsigned DEPTH = bfie_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// push_data [31:0], push_callback [39:32], frame_delta [54:40], zero pad
	input  logic [bfie_pkg::IN_W-1:0]           s_tdata,
	// operation (0 push, 1 tick)
	input  logic                                s_tuser,
	// result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// released [0], callback_fire [1], released_callback [9:2],
	// released_data [41:10], entries_held [41+CNT:42], zero pad
	output logic [((bfie_pkg::RES_BITS + $clog2(DEPTH+1) + 7) / 8) * 8 - 1:0] m_tdata,
	// configuration writes
	input  logic                                cfg_we,
	input  logic [bfie_pkg::CFG_ADDR_W-1:0]     cfg_addr,
	input  logic [bfie_pkg::CFG_W-1:0]          cfg_wdata
);

	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned OUT_W = ((bfie_pkg::RES_BITS + CNT_W + 7) / 8) * 8;

	// configuration registers
	logic [bfie_pkg::MAXC_W-1:0]         max_count_q;
	logic signed [bfie_pkg::TIMER_W-1:0] timer_reload_q;
	logic                                timer_enable_q;

	// input stage
	logic                                valid_s1;
	logic                                op_s1;
	bfie_pkg::entry_t                    item_s1;
	logic [bfie_pkg::DELTA_W-1:0]        delta_s1;

	// result register
	logic                                out_valid_q;
	bfie_pkg::result_t                   result_q;
	logic [CNT_W-1:0]                    occ_q;

	logic                                step;
	logic                                wr_en;
	logic [IDX_W-1:0]                    wr_addr, rd_addr;
	bfie_pkg::entry_t                    head_entry;
	bfie_pkg::result_t                   res;
	logic [CNT_W-1:0]                    occ;

	// the staged item moves on whenever the result register is free or draining
	assign step     = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_count_q    <= bfie_pkg::MAXC_RESET;
			timer_reload_q <= '0;
			timer_enable_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_addr)
				bfie_pkg::CFG_MAX_COUNT:
					max_count_q <= cfg_wdata[bfie_pkg::MAXC_W-1:0];
				bfie_pkg::CFG_TIMER_RELOAD:
					timer_reload_q <= cfg_wdata[bfie_pkg::TIMER_W-1:0];
				bfie_pkg::CFG_TIMER_ENABLE:
					timer_enable_q <= cfg_wdata[0];
				default: begin
					// unused index, write dropped
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1        <= s_tuser;
			item_s1.data <= s_tdata[bfie_pkg::DATA_W-1:0];
			item_s1.cb   <= s_tdata[bfie_pkg::DATA_W +: bfie_pkg::CB_W];
			delta_s1     <= s_tdata[bfie_pkg::DATA_W + bfie_pkg::CB_W +: bfie_pkg::DELTA_W];
		end
	end

	bfie_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.op           (op_s1),
		.item         (item_s1),
		.delta        (delta_s1),
		.max_count    (max_count_q),
		.timer_reload (timer_reload_q),
		.timer_enable (timer_enable_q),
		.head_entry   (head_entry),
		.wr_en        (wr_en),
		.wr_addr      (wr_addr),
		.rd_addr      (rd_addr),
		.res          (res),
		.occ          (occ)
	);

	bfie_store #(
		.DEPTH(DEPTH)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (item_s1),
		.raddr (rd_addr),
		.rdata (head_entry)
	);

	// result register, one transaction per step; the held count tracks the
	// queue from reset on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			occ_q       <= '0;
		end else if (step) begin
			out_valid_q <= 1'b1;
			occ_q       <= occ;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'({occ_q, result_q});

	// occupancy never runs past the storage
	assert property (@(posedge clk) disable iff (!arst_n)
		(occ <= CNT_W'(DEPTH)))
		else $error("occupancy above storage depth");

	// a callback only fires for an entry that actually left
	assert property (@(posedge clk) disable iff (!arst_n)
		(step && res.callback_fire) |-> res.released)
		else $error("callback fired without a release");

	// a push that evicts nothing grows the queue by one
	assert property (@(posedge clk) disable iff (!arst_n)
		(step && (op_s1 == bfie_pkg::OP_PUSH) && !res.released)
		|=> (occ_q == CNT_W'($past(occ_q) + 1'b1)))
		else $error("push without eviction did not add an entry");

	// a tick release shrinks the queue by one
	assert property (@(posedge clk) disable iff (!arst_n)
		(step && (op_s1 == bfie_pkg::OP_TICK) && res.released)
		|=> (occ_q == CNT_W'($past(occ_q) - 1'b1)))
		else $error("tick release did not remove an entry");

endmodule
